### hw/rtl/ltec_pkg.sv
// Shared constants, types and request codes for the tagged-entry LRU cache.
package ltec_pkg;

    localparam int ENTRIES    = 16;
    localparam int DATA_WIDTH = 32;

    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W   = $clog2(ENTRIES + 1);
    localparam int KIND_W  = 3;
    localparam int TAG_W   = 8;
    localparam int KEY_W   = 32;
    localparam int OP_W    = 8;
    localparam int PAY_W   = 32;
    localparam int STAMP_W = 32;
    localparam int TOT_W   = 32;
    localparam int SLOT_W  = 4;
    localparam int OCC_W   = 5;
    localparam int IN_W    = 88;
    localparam int OUT_W   = 120;

    localparam logic [KIND_W-1:0] KIND_LOOKUP  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_PUT     = 3'd1;
    localparam logic [KIND_W-1:0] KIND_INVAL   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_INV_ALL = 3'd3;
    localparam logic [KIND_W-1:0] KIND_CLEAR   = 3'd4;

    localparam logic [OP_W-1:0]  OP_DELETE      = 8'd3;
    localparam logic [TAG_W-1:0] TYPE_COUNT_RST = 8'd16;

    typedef logic [IDX_W-1:0]      t_idx;
    typedef logic [CNT_W-1:0]      t_cnt;
    typedef logic [DATA_WIDTH-1:0] t_data;
    typedef logic [STAMP_W-1:0]    t_stamp;

    // one slot as seen by the scan unit
    typedef struct packed {
        logic              valid;
        logic [KEY_W-1:0]  key;
        logic [TAG_W-1:0]  tag;
        logic [OP_W-1:0]   op;
        t_stamp            stamp;
        t_data             data;
        logic              has_data;
    } t_entry;

    // write-back command to slot storage
    typedef struct packed {
        logic              fill;
        logic              stamp_en;
        logic              inval;
        logic              clr_all;
        t_idx              slot;
        logic [KEY_W-1:0]  key;
        logic [TAG_W-1:0]  tag;
        logic [OP_W-1:0]   op;
        t_stamp            stamp;
        t_data             data;
        logic              has_data;
    } t_wr;

    // scan outcome
    typedef struct packed {
        logic              match;
        t_idx              match_slot;
        logic [OP_W-1:0]   match_op;
        t_data             match_data;
        logic              match_has;
        logic              empty;
        t_idx              empty_slot;
        t_idx              best_slot;
    } t_scan;

endpackage

### hw/rtl/ltec_entries.sv
// Slot storage: per-slot valid and data-present flags plus key, tag, op, stamp and data arrays.
module ltec_entries (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  ltec_pkg::t_idx  i_idx,
    input  ltec_pkg::t_wr   i_wr,
    output ltec_pkg::t_entry o_rd
);
    import ltec_pkg::*;

    logic [ENTRIES-1:0] r_valid;
    logic [ENTRIES-1:0] r_has;
    logic [KEY_W-1:0]   r_key   [ENTRIES];
    logic [TAG_W-1:0]   r_tag   [ENTRIES];
    logic [OP_W-1:0]    r_op    [ENTRIES];
    t_stamp             r_stamp [ENTRIES];
    t_data              r_data  [ENTRIES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_has   <= '0;
        end else if (i_wr.clr_all) begin
            r_valid <= '0;
            r_has   <= '0;
        end else if (i_wr.fill) begin
            r_valid[i_wr.slot] <= 1'b1;
            r_has[i_wr.slot]   <= i_wr.has_data;
        end else if (i_wr.inval) begin
            r_valid[i_wr.slot] <= 1'b0;
            r_has[i_wr.slot]   <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.fill) begin
            r_key[i_wr.slot] <= i_wr.key;
            r_tag[i_wr.slot] <= i_wr.tag;
            r_op[i_wr.slot]  <= i_wr.op;
            if (i_wr.has_data) begin
                r_data[i_wr.slot] <= i_wr.data;
            end
        end
        if (i_wr.stamp_en) begin
            r_stamp[i_wr.slot] <= i_wr.stamp;
        end
    end

    always_comb begin
        o_rd.valid    = r_valid[i_idx];
        o_rd.key      = r_key[i_idx];
        o_rd.tag      = r_tag[i_idx];
        o_rd.op       = r_op[i_idx];
        o_rd.stamp    = r_stamp[i_idx];
        o_rd.data     = r_data[i_idx];
        o_rd.has_data = r_has[i_idx];
    end

endmodule

### hw/rtl/ltec_cmp.sv
// Shared compare unit: one slot per cycle for key match, first empty slot and smallest stamp.
module ltec_cmp (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic                        i_step,
    input  ltec_pkg::t_idx              i_idx,
    input  ltec_pkg::t_entry            i_rd,
    input  logic [ltec_pkg::TAG_W-1:0]  i_tag,
    input  logic [ltec_pkg::KEY_W-1:0]  i_key,
    output ltec_pkg::t_scan             o_scan
);
    import ltec_pkg::*;

    t_scan  r_scan;
    t_stamp r_best_stamp;
    logic   hit_now;

    assign hit_now = i_rd.valid && (i_rd.tag == i_tag) && (i_rd.key == i_key);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan.match <= 1'b0;
            r_scan.empty <= 1'b0;
        end else if (i_start) begin
            r_scan.match     <= 1'b0;
            r_scan.empty     <= 1'b0;
            r_best_stamp     <= '1;
            r_scan.best_slot <= '0;
        end else if (i_step) begin
            if (hit_now && !r_scan.match) begin
                r_scan.match      <= 1'b1;
                r_scan.match_slot <= i_idx;
                r_scan.match_op   <= i_rd.op;
                r_scan.match_data <= i_rd.data;
                r_scan.match_has  <= i_rd.has_data;
            end
            if (!i_rd.valid && !r_scan.empty) begin
                r_scan.empty      <= 1'b1;
                r_scan.empty_slot <= i_idx;
            end
            if (i_rd.valid && (i_rd.stamp < r_best_stamp)) begin
                r_best_stamp     <= i_rd.stamp;
                r_scan.best_slot <= i_idx;
            end
        end
    end

    assign o_scan = r_scan;

endmodule

### hw/rtl/lru_tagged_entry_cache.sv
// Tagged-entry LRU cache top level: request sequencer, statistics and result register.
// A request is scanned against all ENTRIES slots through the single compare unit, one slot per cycle,
// then written back and its result registered; a new request is taken only once the block is back in
// idle, and a result not taken holds the block in write-back.
// Reset (synchronous, active low) empties all slots, zeroes stamp, hit, miss and fill
// counters and sets type_count to 16; no clearing pass, the block is ready right after reset.
module lru_tagged_entry_cache (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [ltec_pkg::TAG_W-1:0]    i_cfg_wdata,    // type_count
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // type_tag[7:0], key_id[39:8], op_code[47:40], payload_in[79:48], payload_given[80]
    input  logic [ltec_pkg::IN_W-1:0]     s_axis_tdata,
    // kind[2:0]
    input  logic [ltec_pkg::KIND_W-1:0]   s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // status[0], hit[1], slot_index[5:2], op_out[13:6], payload_out[45:14],
    // payload_present[46], hit_total[78:47], miss_total[110:79], occupied[115:111]
    output logic [ltec_pkg::OUT_W-1:0]    m_axis_tdata
);
    import ltec_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]        r_state;
    t_idx              r_idx;
    logic [TAG_W-1:0]  r_type_count;
    logic [KIND_W-1:0] r_kind;
    logic [TAG_W-1:0]  r_tag;
    logic [KEY_W-1:0]  r_key;
    logic [OP_W-1:0]   r_op;
    logic [PAY_W-1:0]  r_pay;
    logic              r_given;
    t_stamp            r_stamp_cnt;
    logic [TOT_W-1:0]  r_hits;
    logic [TOT_W-1:0]  r_misses;
    t_cnt              r_fill;
    logic              r_out_valid;
    logic [OUT_W-1:0]  r_out_data;

    t_stamp            n_stamp_cnt;
    logic [TOT_W-1:0]  n_hits;
    logic [TOT_W-1:0]  n_misses;
    t_cnt              n_fill;

    logic              accept;
    logic              finish;
    t_entry            rd;
    t_scan             scan;
    t_wr               wr;
    t_stamp            stamp_nx;
    logic              id_ok;
    logic              status;
    logic              hit;
    t_idx              slot;
    logic [OP_W-1:0]   op_out;
    logic [PAY_W-1:0]  pay_out;
    logic              present;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign finish        = (r_state == ST_DONE) && (!r_out_valid || m_axis_tready);

    ltec_entries u_entries (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_idx   (r_idx),
        .i_wr    (wr),
        .o_rd    (rd)
    );

    ltec_cmp u_cmp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (accept),
        .i_step  (r_state == ST_SCAN),
        .i_idx   (r_idx),
        .i_rd    (rd),
        .i_tag   (r_tag),
        .i_key   (r_key),
        .o_scan  (scan)
    );

    assign stamp_nx = r_stamp_cnt + 1'b1;
    assign id_ok    = (r_key != '0);

    always_comb begin
        n_stamp_cnt = r_stamp_cnt;
        n_hits      = r_hits;
        n_misses    = r_misses;
        n_fill      = r_fill;
        status      = 1'b0;
        hit         = 1'b0;
        slot        = '0;
        op_out      = '0;
        pay_out     = '0;
        present     = 1'b0;
        wr.fill     = 1'b0;
        wr.stamp_en = 1'b0;
        wr.inval    = 1'b0;
        wr.clr_all  = 1'b0;
        wr.key      = r_key;
        wr.tag      = r_tag;
        wr.op       = r_op;
        wr.stamp    = stamp_nx;
        wr.data     = t_data'(r_pay);
        wr.has_data = (r_op != OP_DELETE) && r_given;
        case (r_kind)
            KIND_LOOKUP: begin
                if (!id_ok) begin
                    status = 1'b1;
                end else if (scan.match) begin
                    wr.stamp_en = 1'b1;
                    slot        = scan.match_slot;
                    n_stamp_cnt = stamp_nx;
                    n_hits      = r_hits + 1'b1;
                    hit         = 1'b1;
                    op_out      = scan.match_op;
                    present     = scan.match_has;
                    pay_out     = scan.match_has ? PAY_W'(scan.match_data) : '0;
                end else begin
                    n_misses = r_misses + 1'b1;
                end
            end
            KIND_PUT: begin
                if (!id_ok || (r_tag >= r_type_count)) begin
                    status = 1'b1;
                end else begin
                    wr.fill     = 1'b1;
                    wr.stamp_en = 1'b1;
                    n_stamp_cnt = stamp_nx;
                    if (scan.match) begin
                        slot = scan.match_slot;
                    end else if (scan.empty) begin
                        slot   = scan.empty_slot;
                        n_fill = r_fill + 1'b1;
                    end else begin
                        slot = scan.best_slot;
                    end
                end
            end
            KIND_INVAL: begin
                if (!id_ok) begin
                    status = 1'b1;
                end else if (scan.match) begin
                    wr.inval = 1'b1;
                    slot     = scan.match_slot;
                    if (r_fill != '0) begin
                        n_fill = r_fill - 1'b1;
                    end
                end
            end
            KIND_INV_ALL: begin
                wr.clr_all = 1'b1;
                n_fill     = '0;
            end
            KIND_CLEAR: begin
                wr.clr_all = 1'b1;
                n_fill     = '0;
                n_hits     = '0;
                n_misses   = '0;
            end
            default: begin
                status = 1'b1;
            end
        endcase
        wr.slot     = slot;
        wr.fill     = wr.fill && finish;
        wr.stamp_en = wr.stamp_en && finish;
        wr.inval    = wr.inval && finish;
        wr.clr_all  = wr.clr_all && finish;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_idx        <= '0;
            r_type_count <= TYPE_COUNT_RST;
            r_stamp_cnt  <= '0;
            r_hits       <= '0;
            r_misses     <= '0;
            r_fill       <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_type_count <= i_cfg_wdata;
            end
            case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_idx   <= '0;
                        r_state <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    if (r_idx == IDX_W'(ENTRIES - 1)) begin
                        r_state <= ST_DONE;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                ST_DONE: begin
                    if (finish) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
            if (finish) begin
                r_stamp_cnt <= n_stamp_cnt;
                r_hits      <= n_hits;
                r_misses    <= n_misses;
                r_fill      <= n_fill;
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind  <= s_axis_tuser;
            r_tag   <= s_axis_tdata[7:0];
            r_key   <= s_axis_tdata[39:8];
            r_op    <= s_axis_tdata[47:40];
            r_pay   <= s_axis_tdata[79:48];
            r_given <= s_axis_tdata[80];
        end
        if (finish) begin
            r_out_data <= {4'b0, OCC_W'(n_fill), n_misses, n_hits, present, pay_out,
                           op_out, SLOT_W'(slot), hit, status};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CNT_W'(ENTRIES))
        else $error("occupancy above slot count");

    a_accept_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == ST_SCAN) && (r_idx == '0))
        else $error("request did not start a scan at slot zero");

    a_scan_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) && (r_idx == IDX_W'(ENTRIES - 1)) |=> (r_state == ST_DONE))
        else $error("scan did not end after last slot");

    a_finish_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        finish |=> m_axis_tvalid && (r_state == ST_IDLE))
        else $error("write-back did not present a result");

endmodule
